// ----- rtl/mec_pkg.sv -----
// Package: shared types and constants of the Mahalanobis eigen classifier.
`default_nettype none

package mec_pkg;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_EIGEN  = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         index;
    logic signed [15:0] feature;
    logic signed [15:0] mean;
    logic signed [15:0] component;
    logic [31:0]        eigenvalue;
    logic               last_component;
    logic               last_vector;
    logic [5:0]         class_id;
    logic               last_class;
  } item_t;

  typedef struct packed {
    logic [62:0] distance;
    logic [5:0]  result_class;
    logic [5:0]  best_class;
    logic        final_res;
    logic        zero_eigen;
  } result_t;

  localparam int ACC_W = 48;

  // One finished projection on its way to the back end.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [31:0]             eigenvalue;
    logic                    last_vector;
    logic [5:0]              class_id;
    logic                    last_class;
  } vec_t;

  localparam int Q_DEPTH   = 8;
  localparam int Q_ADDR_W  = 3;
  localparam int Q_CNT_W   = 4;
  localparam int DIV_STEPS = 63;

  localparam logic [62:0] SAT63 = {63{1'b1}};

endpackage

`default_nettype wire

// ----- rtl/mec_if.sv -----
// Interfaces: valid/ready channels for input words and result words.
`default_nettype none

interface mec_item_if;
  import mec_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mec_result_if;
  import mec_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mec_front.sv -----
// Front end: sample store, projection multiply-accumulate, vector hand-off.
`default_nettype none

module mec_front #(
  parameter int DIMENSIONS = 196
) (
  input  logic          clk,
  input  logic          rst,
  mec_item_if.sink      item,
  input  logic          room,
  output logic          push,
  output mec_pkg::vec_t entry
);
  import mec_pkg::*;

  localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  logic signed [16:0] mem [DIMENSIONS];
  logic signed [16:0] rd_data;

  logic          fire;
  logic          idx_ok;
  logic          wr_en;
  logic [AW-1:0] addr;

  logic               s1_valid;
  logic               s1_ok;
  logic signed [15:0] s1_comp;
  logic [31:0]        s1_ev;
  logic               s1_lc;
  logic               s1_lv;
  logic [5:0]         s1_cls;
  logic               s1_lcl;

  logic               s2_valid;
  logic signed [32:0] prod;
  logic [31:0]        s2_ev;
  logic               s2_lc;
  logic               s2_lv;
  logic [5:0]         s2_cls;
  logic               s2_lcl;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] acc_next;

  assign item.ready = room;
  assign fire       = item.valid && item.ready;
  assign idx_ok     = {1'b0, item.data.index} < 9'(DIMENSIONS);
  assign addr       = item.data.index[AW-1:0];
  assign wr_en      = fire && (item.data.func == FUNC_SAMPLE) && idx_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= 17'(item.data.feature) - 17'(item.data.mean);
    end
    rd_data <= mem[addr];
  end

  always_comb begin
    sum = (ACC_W+1)'(acc) + (ACC_W+1)'(prod);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc      <= '0;
    end else begin
      s1_valid <= fire && (item.data.func == FUNC_EIGEN);
      s2_valid <= s1_valid;
      if (s2_valid) begin
        acc <= s2_lc ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ok   <= idx_ok;
    s1_comp <= item.data.component;
    s1_ev   <= item.data.eigenvalue;
    s1_lc   <= item.data.last_component;
    s1_lv   <= item.data.last_vector;
    s1_cls  <= item.data.class_id;
    s1_lcl  <= item.data.last_class;
    if (s1_ok) begin
      prod <= 33'(rd_data) * 33'(s1_comp);
    end else begin
      prod <= '0;
    end
    s2_ev  <= s1_ev;
    s2_lc  <= s1_lc;
    s2_lv  <= s1_lv;
    s2_cls <= s1_cls;
    s2_lcl <= s1_lcl;
  end

  assign push              = s2_valid && s2_lc;
  assign entry.acc         = acc_next;
  assign entry.eigenvalue  = s2_ev;
  assign entry.last_vector = s2_lv;
  assign entry.class_id    = s2_cls;
  assign entry.last_class  = s2_lcl;

endmodule

`default_nettype wire

// ----- rtl/mec_queue.sv -----
// Queue of finished projections between the front and back ends.
`default_nettype none

module mec_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mec_pkg::vec_t entry,
  output logic          room,
  output logic          avail,
  input  logic          pop,
  output mec_pkg::vec_t head
);
  import mec_pkg::*;

  vec_t                slots [Q_DEPTH];
  logic [Q_ADDR_W-1:0] wr_ptr;
  logic [Q_ADDR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  // Up to two words still in the front pipeline may push after acceptance.
  assign room  = count <= Q_CNT_W'(Q_DEPTH - 3);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CNT_W'(Q_DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/mec_back.sv -----
// Back end: square, divide by eigenvalue, class distance, argmin, result word.
`default_nettype none

module mec_back #(
  parameter int MAX_CLASSES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_avail,
  input  mec_pkg::vec_t q_head,
  output logic          q_pop,
  mec_result_if.source  result
);
  import mec_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_CHECK,
    B_DIVIDE,
    B_ACCUM
  } state_t;

  state_t state;

  logic [32:0] mag;
  logic [63:0] sq;
  logic [31:0] ev;
  logic        lv;
  logic [5:0]  cls;
  logic        lcl;
  logic [31:0] rem;
  logic [62:0] quo;
  logic [5:0]  step;

  logic [62:0] class_dist;
  logic        zero_seen;
  logic [62:0] best_dist;
  logic [5:0]  best_idx;

  logic    res_valid;
  result_t res;

  logic [ACC_W:0] neg_round;
  logic [32:0]    mag_in;
  logic [32:0]    trial;
  logic           ge;
  logic [63:0]    dist_sum;
  logic [62:0]    dist_new;
  logic           zero_new;
  logic           take_best;
  logic           emit_ok;
  logic           emit;

  always_comb begin
    neg_round = (ACC_W+1)'(-((ACC_W+1)'(q_head.acc))) + (ACC_W+1)'(32767);
    if (q_head.acc[ACC_W-1]) begin
      mag_in = neg_round[ACC_W-1:15];
    end else begin
      mag_in = {1'b0, q_head.acc[ACC_W-2:15]};
    end
  end

  assign trial     = {rem, quo[62]};
  assign ge        = trial >= {1'b0, ev};
  assign dist_sum  = {1'b0, class_dist} + {1'b0, quo};
  assign dist_new  = dist_sum[63] ? SAT63 : dist_sum[62:0];
  assign zero_new  = zero_seen || (ev == '0);
  assign take_best = (7'(cls) < 7'(MAX_CLASSES)) && (dist_new < best_dist);
  assign emit_ok   = !res_valid || result.ready;
  assign emit      = (state == B_ACCUM) && lv && emit_ok;
  assign q_pop     = (state == B_IDLE) && q_avail;

  assign result.valid = res_valid;
  assign result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      res_valid  <= 1'b0;
      class_dist <= '0;
      zero_seen  <= 1'b0;
      best_dist  <= SAT63;
      best_idx   <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_avail) begin
            mag   <= mag_in;
            ev    <= q_head.eigenvalue;
            lv    <= q_head.last_vector;
            cls   <= q_head.class_id;
            lcl   <= q_head.last_class;
            state <= B_SQUARE;
          end
        end
        B_SQUARE: begin
          if (mag[32]) begin
            sq <= '1;
          end else begin
            sq <= 64'(mag[31:0]) * 64'(mag[31:0]);
          end
          state <= B_CHECK;
        end
        B_CHECK: begin
          // Quotient reaching 2^63 or a zero eigenvalue saturates the term.
          if ((ev == '0) || ({15'b0, sq[63:47]} >= ev)) begin
            quo   <= SAT63;
            state <= B_ACCUM;
          end else begin
            rem   <= {15'b0, sq[63:47]};
            quo   <= {sq[46:0], 16'b0};
            step  <= '0;
            state <= B_DIVIDE;
          end
        end
        B_DIVIDE: begin
          quo  <= {quo[61:0], ge};
          rem  <= ge ? 32'(trial - {1'b0, ev}) : trial[31:0];
          step <= step + 1'b1;
          if (step == 6'(DIV_STEPS - 1)) begin
            state <= B_ACCUM;
          end
        end
        B_ACCUM: begin
          if (!lv) begin
            class_dist <= dist_new;
            zero_seen  <= zero_new;
            state      <= B_IDLE;
          end else if (emit_ok) begin
            res.distance     <= dist_new;
            res.result_class <= cls;
            res.best_class   <= take_best ? cls : best_idx;
            res.final_res    <= lcl;
            res.zero_eigen   <= zero_new;
            class_dist       <= '0;
            zero_seen        <= 1'b0;
            if (lcl) begin
              best_dist <= SAT63;
              best_idx  <= '0;
            end else if (take_best) begin
              best_dist <= dist_new;
              best_idx  <= cls;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIVIDE) |-> (rem < ev))
    else $error("divider remainder not below eigenvalue");
  a_zero_saturates: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.zero_eigen || (res.distance == SAT63)))
    else $error("zero eigenvalue without saturated distance");
  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == B_ACCUM) && lv && lcl && emit_ok) |=>
      ((best_dist == SAT63) && (best_idx == '0)))
    else $error("best class not cleared after final class");
`endif

endmodule

`default_nettype wire

// ----- rtl/mahalanobis_eigen_classifier.sv -----
// Top level: Mahalanobis distance classifier over class eigen decompositions.
//
//   channel  dir  handshake      word
//   item     in   valid/ready    mec_pkg::item_t   (sample element or eigen component)
//   result   out  valid/ready    mec_pkg::result_t (one per class end)
//
// Front takes one word per cycle while the queue has room: samples are stored and
// component multiply-accumulates run through a three-stage pipeline (sample RAM read,
// 17x16 multiply, accumulate). Per vector the back end pops, squares (32x32), range
// checks, divides (63-step radix-2) and accumulates. An 8-deep queue holds finished
// vectors; item.ready drops while 6 or more are waiting. Reset is synchronous; sample
// RAM is not cleared. A stalled result holds the back end in its accumulate step.
`default_nettype none

module mahalanobis_eigen_classifier #(
  parameter int DIMENSIONS  = 196,
  parameter int MAX_CLASSES = 64
) (
  input  logic         clk,
  input  logic         rst,
  mec_item_if.sink     item,
  mec_result_if.source result
);
  import mec_pkg::*;

  logic push;
  vec_t entry;
  logic room;
  logic avail;
  logic pop;
  vec_t head;

  mec_front #(
    .DIMENSIONS(DIMENSIONS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .room (room),
    .push (push),
    .entry(entry)
  );

  mec_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .entry(entry),
    .room (room),
    .avail(avail),
    .pop  (pop),
    .head (head)
  );

  mec_back #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_avail(avail),
    .q_head (head),
    .q_pop  (pop),
    .result (result)
  );

endmodule

`default_nettype wire
